// ===== hdl/wwa_pkg.sv =====
package wwa_pkg;

  typedef enum logic [1:0] {
    ACT_RESET  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FINAL  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] wind_speed;
    logic        speed_valid;
    logic [11:0] wind_direction;
    logic        direction_valid;
    logic [19:0] rain_total;
  } item_t;

  typedef struct packed {
    logic [15:0] sample_count;
    logic [11:0] mean_speed;
    logic [11:0] gust_speed;
    logic [11:0] mean_direction;
    logic [3:0]  compass_point;
    logic [19:0] rain_amount;
  } result_t;

  typedef struct packed {
    action_e     kind;
    logic [11:0] speed;
    logic        speed_ok;
    logic [11:0] dir;
    logic        dir_ok;
    logic [19:0] rain;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG0,
    ST_ANG1,
    ST_ANG2,
    ST_ROT,
    ST_ACC,
    ST_NORM,
    ST_VEC,
    ST_DIV,
    ST_MAP,
    ST_OUT
  } back_state_e;

  // degrees*10 to binary angle: a = d*ANG_MUL + floor((d*ANG_REM + ANG_OFS)/225)
  localparam logic [20:0] ANG_MUL   = 21'd1193046;
  localparam logic [6:0]  ANG_REM   = 7'd106;
  localparam logic [6:0]  ANG_OFS   = 7'd112;
  localparam logic [15:0] RECIP_225 = 16'd37282;
  localparam logic [7:0]  DIV_225   = 8'd225;
  localparam logic [11:0] DIR_FULL  = 12'd3600;
  localparam logic [29:0] CORDIC_X0 = 30'd652032874;
  localparam int          NORM_EXP  = 46;

  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'h20000000;
      5'd1:  return 32'h12E4051E;
      5'd2:  return 32'h09FB385B;
      5'd3:  return 32'h051111D4;
      5'd4:  return 32'h028B0D43;
      5'd5:  return 32'h0145D7E1;
      5'd6:  return 32'h00A2F61E;
      5'd7:  return 32'h00517C55;
      5'd8:  return 32'h0028BE53;
      5'd9:  return 32'h00145F2F;
      5'd10: return 32'h000A2F98;
      5'd11: return 32'h000517CC;
      5'd12: return 32'h00028BE6;
      5'd13: return 32'h000145F3;
      5'd14: return 32'h0000A2FA;
      5'd15: return 32'h0000517D;
      5'd16: return 32'h000028BE;
      5'd17: return 32'h0000145F;
      5'd18: return 32'h00000A30;
      5'd19: return 32'h00000518;
      5'd20: return 32'h0000028C;
      5'd21: return 32'h00000146;
      5'd22: return 32'h000000A3;
      5'd23: return 32'h00000051;
      default: return 32'h0;
    endcase
  endfunction

  // floor((2*md + 225) / 450) mod 16
  function automatic logic [3:0] compass_of(input logic [11:0] md);
    logic [12:0] t;
    logic [4:0]  n;
    t = {md, 1'b0} + 13'd225;
    n = '0;
    for (int k = 1; k <= 16; k++) begin
      if (t >= 13'(450 * k)) n = n + 5'd1;
    end
    return n[3:0];
  endfunction

endpackage

// ===== hdl/wwa_front.sv =====
module wwa_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  wwa_pkg::item_t item_i,
  input  logic           pop_i,
  output wwa_pkg::head_t head_o
);
  import wwa_pkg::*;

  cmd_t       ent_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd;

  always_comb begin
    cmd.kind     = action_e'(item_i.action);
    cmd.speed    = item_i.wind_speed;
    cmd.speed_ok = item_i.speed_valid;
    cmd.dir      = item_i.wind_direction;
    cmd.dir_ok   = item_i.direction_valid;
    cmd.rain     = item_i.rain_total;
  end

  assign busy_o = (cnt_q == 2'd2);
  // unused action code is taken and dropped here
  assign push   = start_i && !busy_o && (item_i.action != ACT_UNUSED);
  assign pop    = pop_i && (cnt_q != 2'd0);

  assign rd_d  = pop ? !rd_q : rd_q;
  assign wr_d  = push ? !wr_q : wr_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= cmd;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_q];

endmodule

// ===== hdl/wwa_back.sv =====
module wwa_back #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wwa_pkg::head_t   head_i,
  output logic             pop_o,
  output logic             done_o,
  output wwa_pkg::result_t result_o
);
  import wwa_pkg::*;

  localparam int P   = COUNT_BITS;
  localparam int SW  = P + 16;
  localparam int SSW = P + 12;
  localparam int VW  = ((P + 16) > 47 ? (P + 16) : 47) + 4;
  localparam int SIW = $clog2(CORDIC_STEPS);
  localparam int DCW = $clog2(P + 12);

  back_state_e state_q, state_d;

  logic [P-1:0]          win_q, cnt_q;
  logic [SSW-1:0]        ssum_q;
  logic [11:0]           peak_q;
  logic signed [SW-1:0]  sin_q, cos_q;
  logic [19:0]           base_q;

  logic [11:0]           dir_q;
  logic [32:0]           prod_q;
  logic [18:0]           frac_q;
  logic [11:0]           q0_q;
  logic signed [VW-1:0]  x_q, y_q;
  logic signed [33:0]    z_q;
  logic                  rot_q, flip_q, zero_q;
  logic [SIW-1:0]        step_q;
  logic [P-1:0]          rem_q;
  logic [SSW-1:0]        num_q;
  logic [11:0]           quo_q;
  logic [DCW-1:0]        dcnt_q;
  logic [11:0]           rnd_q;
  logic [19:0]           rain_q;
  logic                  done_q;
  result_t               res_q;

  logic                  take, last_step, last_div, in_range;
  logic signed [VW-1:0]  xs, ys;
  logic signed [33:0]    tab;
  logic                  up;

  // ---------------- next state
  assign take      = (state_q == ST_IDLE) && head_i.valid;
  assign last_step = (step_q == SIW'(CORDIC_STEPS - 1));
  assign last_div  = (dcnt_q == DCW'(P + 11));
  assign in_range  = (x_q < (VW'(1) <<< NORM_EXP)) && (x_q > -(VW'(1) <<< NORM_EXP)) &&
                     (y_q < (VW'(1) <<< NORM_EXP)) && (y_q > -(VW'(1) <<< NORM_EXP));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (head_i.cmd.kind)
            ACT_SAMPLE: if (head_i.cmd.dir_ok) state_d = ST_ANG0;
            ACT_FINAL:  state_d = (sin_q == '0 && cos_q == '0) ? ST_VEC : ST_NORM;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ANG0: state_d = ST_ANG1;
      ST_ANG1: state_d = ST_ANG2;
      ST_ANG2: state_d = ST_ROT;
      ST_ROT:  if (last_step) state_d = ST_ACC;
      ST_ACC:  state_d = ST_IDLE;
      ST_NORM: if (!in_range) state_d = ST_VEC;
      ST_VEC:  if (last_step) state_d = ST_DIV;
      ST_DIV:  if (last_div) state_d = ST_MAP;
      ST_MAP:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ---------------- outputs
  always_comb begin
    pop_o    = take;
    done_o   = done_q;
    result_o = res_q;
  end

  // ---------------- shared CORDIC step
  always_comb begin
    xs  = x_q >>> step_q;
    ys  = y_q >>> step_q;
    tab = 34'(atan_tab(5'(step_q)));
    up  = rot_q ? !z_q[33] : y_q[VW-1];
  end

  function automatic logic signed [15:0] to_q15(input logic signed [VW-1:0] v);
    logic signed [VW:0] r;
    r = (signed'({v[VW-1], v}) + (VW+1)'(16384)) >>> 15;
    if (r > (VW+1)'(32767))       return 16'sh7FFF;
    else if (r < -(VW+1)'(32768)) return 16'sh8000;
    else                          return r[15:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [15:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + (SW+1)'(b);
    if (s[SW] != s[SW-1]) return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    else                  return s[SW-1:0];
  endfunction

  logic [34:0]          recip_prod;
  logic [18:0]          rmd;
  logic [11:0]          qc;
  logic [31:0]          ang;
  logic signed [33:0]   za;
  logic signed [VW-1:0] fx, fy, cx, cy;
  logic [SSW:0]         ssum_add;
  logic [P:0]           trial;
  logic [43:0]          map_prod;
  logic [11:0]          md;

  always_comb begin
    recip_prod = 35'(frac_q) * 35'(RECIP_225);
    rmd        = frac_q - 19'(q0_q) * 19'(DIV_225);
    qc         = q0_q + 12'(rmd >= 19'(DIV_225));
    ang        = 32'(prod_q + 33'(qc));
    za         = 34'(signed'(ang));
    fx         = flip_q ? -x_q : x_q;
    fy         = flip_q ? -y_q : y_q;
    cx         = VW'(cos_q);
    cy         = VW'(sin_q);
    ssum_add   = {1'b0, ssum_q} + (SSW+1)'(head_i.cmd.speed);
    trial      = {rem_q, num_q[SSW-1]};
    map_prod   = 44'(z_q[31:0]) * 44'(DIR_FULL) + 44'h0_8000_0000;
    md         = (zero_q || rnd_q >= DIR_FULL) ? 12'd0 : rnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      ssum_q <= '0;
      peak_q <= '0;
      sin_q  <= '0;
      cos_q  <= '0;
      base_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_OUT);
      if (take) begin
        case (head_i.cmd.kind)
          ACT_RESET: begin
            win_q  <= '0;
            cnt_q  <= '0;
            ssum_q <= '0;
            peak_q <= '0;
            sin_q  <= '0;
            cos_q  <= '0;
            base_q <= head_i.cmd.rain;
          end
          ACT_SAMPLE: begin
            if (win_q != '1) win_q <= win_q + P'(1);
            if (head_i.cmd.speed_ok) begin
              ssum_q <= ssum_add[SSW] ? '1 : ssum_add[SSW-1:0];
              if (cnt_q != '1) cnt_q <= cnt_q + P'(1);
              if (head_i.cmd.speed > peak_q) peak_q <= head_i.cmd.speed;
            end
          end
          default: ;
        endcase
      end
      if (state_q == ST_ACC) begin
        sin_q <= sat_add(sin_q, to_q15(fy));
        cos_q <= sat_add(cos_q, to_q15(fx));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dir_q  <= head_i.cmd.dir;
        rain_q <= (head_i.cmd.rain > base_q) ? head_i.cmd.rain - base_q : 20'd0;
        zero_q <= (sin_q == '0 && cos_q == '0);
        rot_q  <= 1'b0;
        step_q <= '0;
        num_q  <= ssum_q;
        rem_q  <= '0;
        dcnt_q <= '0;
        if (cos_q[SW-1]) begin
          x_q <= -cx;
          y_q <= -cy;
          z_q <= 34'sh0_8000_0000;
        end else begin
          x_q <= cx;
          y_q <= cy;
          z_q <= '0;
        end
      end
      ST_ANG0: begin
        prod_q <= 33'(dir_q) * 33'(ANG_MUL);
        frac_q <= 19'(dir_q) * 19'(ANG_REM) + 19'(ANG_OFS);
      end
      ST_ANG1: q0_q <= recip_prod[34:23];
      ST_ANG2: begin
        rot_q  <= 1'b1;
        step_q <= '0;
        x_q    <= VW'(CORDIC_X0);
        y_q    <= '0;
        if (za > (34'sd1 <<< 30)) begin
          z_q    <= za - (34'sd1 <<< 31);
          flip_q <= 1'b1;
        end else if (za < -(34'sd1 <<< 30)) begin
          z_q    <= za + (34'sd1 <<< 31);
          flip_q <= 1'b1;
        end else begin
          z_q    <= za;
          flip_q <= 1'b0;
        end
      end
      ST_ROT, ST_VEC: begin
        step_q <= step_q + SIW'(1);
        if (up) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - tab;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + tab;
        end
      end
      ST_NORM: if (in_range) begin
        x_q <= x_q <<< 1;
        y_q <= y_q <<< 1;
      end
      ST_DIV: begin
        dcnt_q <= dcnt_q + DCW'(1);
        num_q  <= num_q << 1;
        if (trial >= {1'b0, cnt_q}) begin
          rem_q <= P'(trial - {1'b0, cnt_q});
          quo_q <= {quo_q[10:0], 1'b1};
        end else begin
          rem_q <= trial[P-1:0];
          quo_q <= {quo_q[10:0], 1'b0};
        end
      end
      ST_MAP: rnd_q <= map_prod[43:32];
      ST_OUT: begin
        res_q.sample_count   <= (win_q > P'(65535)) ? 16'hFFFF : 16'(win_q);
        res_q.mean_speed     <= (cnt_q == '0) ? 12'd0 : quo_q;
        res_q.gust_speed     <= peak_q;
        res_q.mean_direction <= md;
        res_q.compass_point  <= compass_of(md);
        res_q.rain_amount    <= rain_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/wind_window_aggregator.sv =====
// Wind and rain window aggregator.
// Input: item_i is taken when start_i is high and busy_o is low. action 0
// clears the window and stores rain_total as baseline, 1 adds a sample,
// 2 reports; action 3 is taken and ignored.
// Output: one result per report, on result_o for one cycle with done_o high.
// The receiver cannot stall; results are never held.
// A two-entry command queue lets a new transaction in while the back end
// works; busy_o rises only when the queue is full.
// Back-end steps per transaction (single shared CORDIC datapath):
//   reset window, or sample without valid direction: taken in idle
//   sample with valid direction: angle conversion, CORDIC rotation,
//   accumulation into the direction sum
//   report: normalization shifts (skipped for an all-zero direction sum),
//   CORDIC vectoring, restoring divide, angle-to-degrees mapping, output.
//   done_o follows in the cycle after the last back-end cycle.
// Reset clears all window state, the queue and the output strobe.
module wind_window_aggregator #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  wwa_pkg::item_t   item_i,
  output logic             done_o,
  output wwa_pkg::result_t result_o
);
  import wwa_pkg::*;

  head_t head;
  logic  pop;

  wwa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .item_i  (item_i),
    .pop_i   (pop),
    .head_o  (head)
  );

  wwa_back #(
    .COUNT_BITS   (COUNT_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== hdl/wwa_checker.sv =====
module wwa_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy_o,
  input logic             done_o,
  input wwa_pkg::result_t result_o
);
  import wwa_pkg::*;

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.mean_direction < DIR_FULL))
    else $error("mean direction out of range");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.sample_count == 16'd0) |->
      (result_o.gust_speed == 12'd0 && result_o.mean_speed == 12'd0))
    else $error("speed reported for empty window");

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({busy_o, done_o}))
    else $error("handshake outputs unknown");

endmodule

bind wind_window_aggregator wwa_checker u_wwa_checker (.*);
